FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MSSP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// An implication that must hold at every clock edge outside reset.
`define MSSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mssp_pkg.sv
`default_nettype none
package mssp_pkg;

  localparam int POOL_ENTRIES = 16;
  localparam int MAX_STACKS   = 8;
  localparam int DATA_WIDTH   = 32;

  localparam int IDX_W       = $clog2(POOL_ENTRIES);
  localparam int PTR_W       = $clog2(POOL_ENTRIES + 1);
  localparam int STACK_IDX_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;

  localparam int OPCODE_W    = 1;
  localparam int STACK_NUM_W = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_STACK = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic commit;
  } mssp_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/mssp_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module mssp_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire mssp_pkg::mssp_cmd_t                cmd_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [mssp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic [mssp_pkg::OPCODE_W-1:0]      opcode_i,
  input  wire logic [mssp_pkg::STACK_NUM_W-1:0]   stack_number_i,
  input  wire logic signed [mssp_pkg::VALUE_W-1:0] push_value_i,
  output logic signed [mssp_pkg::VALUE_W-1:0]     popped_value_o,
  output logic [mssp_pkg::STATUS_W-1:0]           status_o
);
  import mssp_pkg::*;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_ENTRIES);

  logic [CFG_W-1:0]       cfg_q;
  logic [PTR_W-1:0]       free_head_q;
  logic [PTR_W-1:0]       top_q [MAX_STACKS];
  logic [POOL_ENTRIES-1:0] link_vld_q;

  logic [PTR_W-1:0]       link_mem [POOL_ENTRIES];
  logic [DATA_WIDTH-1:0]  data_mem [POOL_ENTRIES];

  opcode_e                op_q;
  logic [STACK_IDX_W-1:0] sn_q;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [PTR_W-1:0]       e_q;
  status_e                status_q;
  logic [PTR_W-1:0]       rd_link_q;
  logic                   rd_link_vld_q;
  logic [DATA_WIDTH-1:0]  rd_data_q;
  logic [VALUE_W-1:0]     out_value_q;
  status_e                out_status_q;

  logic [STACK_IDX_W-1:0] sn_idx;
  logic                   sn_valid;
  logic [PTR_W-1:0]       e_d;
  status_e                status_d;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic [PTR_W-1:0]       link_raw;
  logic [PTR_W-1:0]       nxt;
  logic                   commit_ok;

  always_comb begin
    sn_idx   = STACK_IDX_W'(stack_number_i);
    sn_valid = (int'(stack_number_i) < int'(cfg_q)) && (int'(stack_number_i) < MAX_STACKS);
    e_d      = (opcode_e'(opcode_i) == OP_POP) ? top_q[sn_idx] : free_head_q;
    if (!sn_valid) begin
      status_d = ST_BAD_STACK;
    end else if (e_d >= NULL_PTR) begin
      status_d = (opcode_e'(opcode_i) == OP_POP) ? ST_EMPTY : ST_FULL;
    end else begin
      status_d = ST_OK;
    end
    rd_addr   = e_d[IDX_W-1:0];
    wr_addr   = e_q[IDX_W-1:0];
    link_raw  = rd_link_vld_q ? rd_link_q : (e_q + PTR_W'(1));
    nxt       = (link_raw < NULL_PTR) ? link_raw : NULL_PTR;
    commit_ok = cmd_i.commit && (status_q == ST_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      free_head_q <= '0;
      link_vld_q  <= '0;
      status_q    <= ST_OK;
      e_q         <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        top_q[i] <= NULL_PTR;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        status_q <= status_d;
        e_q      <= e_d;
      end
      if (commit_ok) begin
        link_vld_q[wr_addr] <= 1'b1;
        if (op_q == OP_PUSH) begin
          free_head_q <= nxt;
          top_q[sn_q] <= e_q;
        end else begin
          free_head_q <= e_q;
          top_q[sn_q] <= nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q          <= opcode_e'(opcode_i);
      sn_q          <= sn_idx;
      val_q         <= DATA_WIDTH'($unsigned(push_value_i));
      rd_link_q     <= link_mem[rd_addr];
      rd_link_vld_q <= link_vld_q[rd_addr];
      rd_data_q     <= data_mem[rd_addr];
    end
    if (commit_ok) begin
      if (op_q == OP_PUSH) begin
        data_mem[wr_addr] <= val_q;
        link_mem[wr_addr] <= top_q[sn_q];
      end else begin
        link_mem[wr_addr] <= free_head_q;
      end
    end
    if (cmd_i.commit) begin
      out_value_q  <= (commit_ok && op_q == OP_POP) ? VALUE_W'(rd_data_q) : '0;
      out_status_q <= status_q;
    end
  end

  assign popped_value_o = out_value_q;
  assign status_o       = out_status_q;

  `MSSP_ASSERT(a_ok_entry_in_pool, clk_i, rst_ni, (status_q != ST_OK) || (e_q < NULL_PTR))
  `MSSP_ASSERT_NEXT(a_push_moves_free_head, clk_i, rst_ni,
                    commit_ok && (op_q == OP_PUSH), free_head_q != $past(e_q))

endmodule
`default_nettype wire

FILE: rtl/core/mssp_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module mssp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output mssp_pkg::mssp_cmd_t      cmd_o
);
  import mssp_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == S_IDLE);
    cmd_o.commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `MSSP_ASSERT_NEXT(a_accept_blocks_input, clk_i, rst_ni, cmd_o.accept, in_stall_o)
  `MSSP_ASSERT_NEXT(a_commit_shows_result, clk_i, rst_ni, cmd_o.commit,
                    out_valid_o && !in_stall_o)
  `MSSP_ASSERT(a_no_overlap, clk_i, rst_ni, !(cmd_o.accept && cmd_o.commit))

endmodule
`default_nettype wire

FILE: rtl/core/multi_stack_shared_pool.sv
`default_nettype none
// Several stacks share one pool of entries held on linked lists. Each request is a push or a
// pop on one stack and gives exactly one result with a status code. When a request is taken,
// the top or free-list pointer is selected and the link and data stores are read into
// registers; the execute state then updates the lists and loads the output register. A new
// request is not taken until the last one has updated the lists, and a result left waiting in
// the output register holds the next request in its execute state. The user must write the
// stacks-in-use register only while no request is in flight; the block does not enforce this.
module multi_stack_shared_pool (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mssp_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [mssp_pkg::OPCODE_W-1:0]       opcode_i,
  input  wire logic [mssp_pkg::STACK_NUM_W-1:0]    stack_number_i,
  input  wire logic signed [mssp_pkg::VALUE_W-1:0] push_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [mssp_pkg::VALUE_W-1:0]      popped_value_o,
  output logic [mssp_pkg::STATUS_W-1:0]            status_o
);
  import mssp_pkg::*;

  mssp_cmd_t cmd;

  mssp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mssp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .stack_number_i (stack_number_i),
    .push_value_i   (push_value_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
module testbench;
  import mssp_pkg::*;

  localparam int NULL_IDX    = POOL_ENTRIES;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_e                   status;
  } pop_outcome_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]            cfg_wdata_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic [OPCODE_W-1:0]         opcode_i       = '0;
  logic [STACK_NUM_W-1:0]      stack_number_i = '0;
  logic signed [VALUE_W-1:0]   push_value_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic signed [VALUE_W-1:0]   popped_value_o;
  logic [STATUS_W-1:0]         status_o;

  multi_stack_shared_pool dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .stack_number_i (stack_number_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the pool: stack tops, entry links and data, and the free-list head.
  logic [4:0]               top_of_stack [MAX_STACKS];
  logic [4:0]               entry_next   [POOL_ENTRIES];
  logic [VALUE_W-1:0]       entry_value  [POOL_ENTRIES];
  logic [4:0]               free_ptr;
  logic [CFG_W-1:0]         stacks_in_use;

  pop_outcome_t outcome_queue [$];

  int  errors      = 0;
  int  cycle_count = 0;
  int  stall_hold  = 0;
  bit  no_idle     = 1'b0;
  int  requests_sent = 0;
  int  status_seen [4] = '{0, 0, 0, 0};

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL multi_stack_shared_pool");
      $finish;
    end
  end

  function automatic int usable_stacks();
    return (stacks_in_use > MAX_STACKS) ? MAX_STACKS : int'(stacks_in_use);
  endfunction

  task automatic reset_pool_mirror();
    for (int i = 0; i < MAX_STACKS; i++) top_of_stack[i] = 5'(NULL_IDX);
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      entry_value[i] = '0;
      entry_next[i]  = 5'((i + 1 < POOL_ENTRIES) ? i + 1 : NULL_IDX);
    end
    free_ptr      = '0;
    stacks_in_use = CFG_RESET;
  endtask

  task automatic predict_request(input opcode_e op, input logic [2:0] sn,
                                 input logic [VALUE_W-1:0] val);
    pop_outcome_t res;
    logic [4:0]   e;
    logic [4:0]   nxt;
    res.value  = '0;
    res.status = ST_OK;
    if (int'(sn) >= usable_stacks()) begin
      res.status = ST_BAD_STACK;
    end else if (op == OP_PUSH) begin
      e = free_ptr;
      if (e >= NULL_IDX) begin
        res.status = ST_FULL;
      end else begin
        nxt            = entry_next[e[3:0]];
        free_ptr       = (nxt < NULL_IDX) ? nxt : 5'(NULL_IDX);
        entry_value[e[3:0]] = val;
        entry_next[e[3:0]]  = top_of_stack[sn];
        top_of_stack[sn]    = e;
      end
    end else begin
      e = top_of_stack[sn];
      if (e >= NULL_IDX) begin
        res.status = ST_EMPTY;
      end else begin
        nxt                = entry_next[e[3:0]];
        res.value          = entry_value[e[3:0]];
        top_of_stack[sn]   = (nxt < NULL_IDX) ? nxt : 5'(NULL_IDX);
        entry_next[e[3:0]] = free_ptr;
        free_ptr           = e;
      end
    end
    outcome_queue.push_back(res);
  endtask

  // Sends one request after a random gap (none when no_idle is set) and records its outcome once accepted.
  task automatic issue_request(input opcode_e op, input logic [2:0] sn,
                               input logic [VALUE_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    stack_number_i <= sn;
    push_value_i   <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(op, sn, val);
    requests_sent++;
  endtask

  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    while (outcome_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_stacks_in_use(input logic [CFG_W-1:0] v);
    drain_outcomes();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stacks_in_use = v;
  endtask

  task automatic check_outcome();
    pop_outcome_t exp;
    if (outcome_queue.size() == 0) begin
      $display("%0t: unexpected result, actual value %0d status %0d",
               $time, popped_value_o, status_o);
      errors++;
    end else begin
      exp = outcome_queue.pop_front();
      if (popped_value_o !== exp.value) begin
        $display("%0t: popped_value expected %0d, actual %0d",
                 $time, exp.value, popped_value_o);
        errors++;
      end
      if (status_o !== exp.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, exp.status, status_o);
        errors++;
      end
      status_seen[exp.status]++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_outcome();
        stall_hold = no_idle ? 0 : $urandom_range(0, 9);
        out_stall_i <= (stall_hold != 0);
      end else if (stall_hold > 0) begin
        stall_hold--;
        out_stall_i <= (stall_hold != 0);
      end
    end
  end

  task automatic test_basic_operations();
    issue_request(OP_POP,  3'd0, 32'h0);
    issue_request(OP_PUSH, 3'd0, 32'h7fffffff);
    issue_request(OP_PUSH, 3'd0, 32'h80000000);
    issue_request(OP_PUSH, 3'd7, 32'hffffffff);
    issue_request(OP_PUSH, 3'd7, 32'h0);
    issue_request(OP_POP,  3'd0, 32'hffffffff);
    issue_request(OP_POP,  3'd7, 32'h0);
    issue_request(OP_POP,  3'd7, 32'h0);
    issue_request(OP_POP,  3'd7, 32'h0);
    issue_request(OP_POP,  3'd0, 32'h0);
  endtask

  task automatic test_stack_limit();
    set_stacks_in_use(4'd4);
    issue_request(OP_PUSH, 3'd4, 32'h12345678);
    issue_request(OP_POP,  3'd7, 32'h0);
    issue_request(OP_PUSH, 3'd3, 32'h5);
    issue_request(OP_POP,  3'd4, 32'h0);
    issue_request(OP_POP,  3'd3, 32'h0);
    // Values above the number of stacks saturate; zero rejects everything.
    set_stacks_in_use(4'd15);
    issue_request(OP_PUSH, 3'd7, 32'd123);
    issue_request(OP_POP,  3'd7, 32'h0);
    set_stacks_in_use(4'd0);
    issue_request(OP_PUSH, 3'd0, 32'd9);
    issue_request(OP_POP,  3'd0, 32'h0);
    set_stacks_in_use(4'd1);
    issue_request(OP_PUSH, 3'd0, 32'hdeadbeef);
    issue_request(OP_PUSH, 3'd1, 32'd1);
    issue_request(OP_POP,  3'd0, 32'h0);
  endtask

  task automatic test_pool_exhaustion();
    set_stacks_in_use(4'd3);
    for (int i = 0; i < POOL_ENTRIES; i++) issue_request(OP_PUSH, 3'(i % 3), $urandom);
    issue_request(OP_PUSH, 3'd2, $urandom);
    // With the pool full, an invalid stack number still takes precedence.
    issue_request(OP_PUSH, 3'd5, $urandom);
    issue_request(OP_POP,  3'd0, 32'h0);
    issue_request(OP_PUSH, 3'd1, $urandom);
    issue_request(OP_PUSH, 3'd0, $urandom);
    for (int i = 0; i < 21; i++) issue_request(OP_POP, 3'(i % 3), 32'h0);
  endtask

  task automatic random_phase(input int count, input int push_pct);
    logic [VALUE_W-1:0] val;
    logic [2:0]         sn;
    opcode_e            op;
    int                 lim;
    for (int i = 0; i < count; i++) begin
      lim = usable_stacks();
      op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      if (lim > 0 && $urandom_range(0, 9) != 0) sn = 3'($urandom_range(0, lim - 1));
      else sn = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 11))
        0: val = 32'h80000000;
        1: val = 32'h7fffffff;
        2: val = 32'hffffffff;
        3: val = 32'h0;
        default: val = $urandom;
      endcase
      issue_request(op, sn, val);
    end
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings [7] = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd5, 4'd2, 4'd8};
    int               mix [4] = '{75, 25, 60, 35};
    foreach (settings[k]) begin
      set_stacks_in_use(settings[k]);
      foreach (mix[m]) begin
        no_idle = ($urandom_range(0, 3) == 0);
        random_phase(45, mix[m]);
      end
      no_idle = 1'b0;
    end
    set_stacks_in_use(4'd0);
    random_phase(30, 50);
  endtask

  initial begin
    reset_pool_mirror();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_operations();
    test_stack_limit();
    test_pool_exhaustion();
    test_random_traffic();
    drain_outcomes();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests over stack limits 0, 1 to 5, 8 and 15.", requests_sent);
    $display("Results: %0d ok, %0d pool full, %0d invalid stack, %0d empty stack.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD_STACK],
             status_seen[ST_EMPTY]);
    if (errors == 0) begin
      $display("PASS multi_stack_shared_pool");
    end else begin
      $display("FAIL multi_stack_shared_pool");
    end
    $finish;
  end

endmodule
